### rtl/core/cvr_pkg.sv
// ----------------------------------------------------------------------------
// cvr_pkg
// Types and codes shared by the circular value ring controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cvr_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_ROTATE = 2'd2;
  localparam logic [1:0] CMD_FIND   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [2:0] K_EMPTY = 3'd0;
  localparam logic [2:0] K_FULL  = 3'd1;
  localparam logic [2:0] K_HIT   = 3'd2;
  localparam logic [2:0] K_MISS  = 3'd3;
  localparam logic [2:0] K_NEW   = 3'd4;
  localparam logic [2:0] K_UPD   = 3'd5;
  localparam logic [2:0] K_ROT   = 3'd6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [3:0]         slot;
    logic signed [31:0] slot_value;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       rd_link;
    logic       wr_new;
    logic       wr_fix;
    logic       wr_upd;
    logic       commit_hit;
    logic       commit_ins;
    logic       commit_rot;
    logic       emit;
    logic [2:0] kind;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/cvr_datapath.sv
// ----------------------------------------------------------------------------
// cvr_datapath
// Slot memories, cursor and tail registers, search counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cvr_datapath #(
  parameter int CAPACITY = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cvr_pkg::in_t  in_data,
  input  wire cvr_pkg::ctl_t ctl,
  output cvr_pkg::sts_t      sts,
  output logic               out_valid,
  output cvr_pkg::out_t      out_data
);
  import cvr_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] val_mem  [CAPACITY];
  logic [SW-1:0]      next_mem [CAPACITY];
  logic [SW-1:0]      prev_mem [CAPACITY];

  logic [SW-1:0]      cursor_r, tail_r;
  logic [CW-1:0]      used_r, cnt_r;
  logic signed [31:0] value_r;
  logic signed [31:0] rd_val_r;
  logic [SW-1:0]      rd_next_r, rd_prev_r, rd_slot_r;
  logic               out_valid_r;
  out_t               out_data_r, out_nxt;

  logic [SW-1:0]      rd_addr;
  logic [SW-1:0]      new_slot;
  logic [CW-1:0]      cnt_plus;

  function automatic logic [3:0] slot_code(input logic [SW-1:0] s);
    logic [31:0] ext;
    ext = 32'(s);
    return ext[3:0];
  endfunction

  assign rd_addr  = ctl.rd_link ? rd_next_r : cursor_r;
  assign new_slot = used_r[SW-1:0];
  assign cnt_plus = cnt_r + CW'(1);

  assign sts.empty = (used_r == '0);
  assign sts.full  = (used_r == CW'(CAPACITY));
  assign sts.match = (rd_val_r == value_r);
  assign sts.last  = (cnt_plus == used_r);

  always_ff @(posedge clk) begin
    if (ctl.wr_new) begin
      val_mem[new_slot] <= value_r;
    end else if (ctl.wr_upd) begin
      val_mem[cursor_r] <= value_r;
    end
    rd_val_r <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_new) begin
      next_mem[new_slot] <= cursor_r;
    end else if (ctl.wr_fix) begin
      next_mem[tail_r] <= new_slot;
    end
    rd_next_r <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_new) begin
      prev_mem[new_slot] <= tail_r;
    end else if (ctl.wr_fix) begin
      prev_mem[cursor_r] <= new_slot;
    end
    rd_prev_r <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= rd_addr;
    if (ctl.load) begin
      value_r <= in_data.value;
    end
    if (ctl.cnt_clr) begin
      cnt_r <= '0;
    end else if (ctl.cnt_inc) begin
      cnt_r <= cnt_plus;
    end
    out_data_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      tail_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
      if (ctl.commit_hit) begin
        cursor_r <= rd_slot_r;
        tail_r   <= rd_prev_r;
      end else if (ctl.commit_rot) begin
        cursor_r <= rd_next_r;
        tail_r   <= cursor_r;
      end else if (ctl.commit_ins) begin
        tail_r <= new_slot;
        used_r <= used_r + CW'(1);
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    case (ctl.kind)
      K_EMPTY: out_nxt.status = ST_EMPTY;
      K_FULL:  out_nxt.status = ST_FULL;
      K_HIT: begin
        out_nxt.found      = 1'b1;
        out_nxt.slot       = slot_code(rd_slot_r);
        out_nxt.slot_value = rd_val_r;
      end
      K_MISS:  out_nxt.status = ST_DONE;
      K_NEW: begin
        out_nxt.slot       = slot_code(new_slot);
        out_nxt.slot_value = value_r;
      end
      K_UPD: begin
        out_nxt.slot       = slot_code(cursor_r);
        out_nxt.slot_value = value_r;
      end
      K_ROT: begin
        out_nxt.slot       = slot_code(rd_slot_r);
        out_nxt.slot_value = rd_val_r;
      end
      default: out_nxt = '0;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/core/cvr_ctrl.sv
// ----------------------------------------------------------------------------
// cvr_ctrl
// Command sequencer: search walk, link insert (new-slot write, then link fix), update and rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module cvr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    in_cmd,
  input  wire cvr_pkg::sts_t sts,
  output cvr_pkg::ctl_t      ctl,
  output logic               busy
);
  import cvr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_WNEW   = 3'd2;
  localparam logic [2:0] S_WFIX   = 3'd3;
  localparam logic [2:0] S_UPD    = 3'd4;
  localparam logic [2:0] S_ROT    = 3'd5;
  localparam logic [2:0] S_ROT2   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       is_ins_r, is_ins_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      is_ins_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      is_ins_r <= is_ins_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    is_ins_nxt = is_ins_r;
    ctl        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load    = 1'b1;
          ctl.cnt_clr = 1'b1;
          is_ins_nxt  = (in_cmd == CMD_INSERT);
          if (in_cmd == CMD_INSERT) begin
            state_nxt = sts.empty ? S_WNEW : S_SEARCH;
          end else if (sts.empty) begin
            ctl.emit = 1'b1;
            ctl.kind = K_EMPTY;
          end else begin
            case (in_cmd)
              CMD_UPDATE: state_nxt = S_UPD;
              CMD_ROTATE: state_nxt = S_ROT;
              CMD_FIND:   state_nxt = S_SEARCH;
              default:    state_nxt = S_IDLE;
            endcase
          end
        end
      end
      S_SEARCH: begin
        if (sts.match) begin
          ctl.emit       = 1'b1;
          ctl.kind       = K_HIT;
          ctl.commit_hit = is_ins_r;
          state_nxt      = S_IDLE;
        end else if (sts.last) begin
          if (!is_ins_r) begin
            ctl.emit  = 1'b1;
            ctl.kind  = K_MISS;
            state_nxt = S_IDLE;
          end else if (sts.full) begin
            ctl.emit  = 1'b1;
            ctl.kind  = K_FULL;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_WNEW;
          end
        end else begin
          ctl.cnt_inc = 1'b1;
          ctl.rd_link = 1'b1;
        end
      end
      S_WNEW: begin
        ctl.wr_new = 1'b1;
        state_nxt  = S_WFIX;
      end
      S_WFIX: begin
        ctl.wr_fix     = 1'b1;
        ctl.commit_ins = 1'b1;
        ctl.emit       = 1'b1;
        ctl.kind       = K_NEW;
        state_nxt      = S_IDLE;
      end
      S_UPD: begin
        ctl.wr_upd = 1'b1;
        ctl.emit   = 1'b1;
        ctl.kind   = K_UPD;
        state_nxt  = S_IDLE;
      end
      S_ROT: begin
        ctl.rd_link    = 1'b1;
        ctl.commit_rot = 1'b1;
        state_nxt      = S_ROT2;
      end
      S_ROT2: begin
        ctl.emit  = 1'b1;
        ctl.kind  = K_ROT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/circular_value_ring_with_cursor_unit.sv
// ----------------------------------------------------------------------------
// circular_value_ring_with_cursor_unit
// Ring of signed 32-bit values with a cursor: insert, update, rotate, find.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data and raise start; the item is taken at an edge where busy
//   is low. Exactly one result per item appears on out_data for one cycle
//   with out_valid high; the receiver must take it then.
//   Items are taken one at a time, with busy high until the result is
//   shown:
//     - update, rotate or find on an empty ring: result after the accept
//     - update: a slot write state; rotate: a link read state, then a result state
//     - insert or find: the search walk, one slot per cycle through the
//       link memory read port, until a match or the last used slot
//     - insert miss: the search, then the new-slot write and link fix states
//   A new item may be started in the cycle the result is shown.
//   Reset clears the cursor, tail, slot count and controller; the slot
//   memories are not cleared, only slots already handed out are read.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_value_ring_with_cursor_unit #(
  parameter int CAPACITY = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire cvr_pkg::in_t in_data,
  output logic              out_valid,
  output cvr_pkg::out_t     out_data
);
  import cvr_pkg::*;

  ctl_t ctl;
  sts_t sts;

  cvr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_data.cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  cvr_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/core/cvr_checker.sv
// ----------------------------------------------------------------------------
// cvr_checker
// Port-level properties of the circular value ring, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cvr_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire cvr_pkg::out_t out_data
);
  import cvr_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted item neither answered nor in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_DONE || out_data.status == ST_EMPTY ||
                   out_data.status == ST_FULL))
    else $error("undefined status");

  a_fail_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_DONE) |->
      (!out_data.found && out_data.slot == '0 && out_data.slot_value == '0))
    else $error("failed command carries data");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |-> (out_data.status == ST_DONE))
    else $error("match reported with failing status");

endmodule

bind circular_value_ring_with_cursor_unit cvr_checker u_cvr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
